>>> hdl/ctxrans_pkg.sv
// Shared constants and types for the context-adaptive binary rANS decoder.
// No dependencies.
`timescale 1ns / 1ps

package ctxrans_pkg;

  localparam int CONTEXTS  = 16;
  localparam int CTX_AW    = $clog2(CONTEXTS);
  localparam int CTX_W     = 4;
  localparam int PROB_W    = 12;
  localparam int STATE_W   = 32;
  localparam int SCALE_W   = 14;

  localparam logic [CTX_W-1:0]   FIXED_CTX  = 4'd15;
  localparam logic [PROB_W-1:0]  PROB_HALF  = 12'd2048;
  localparam logic [PROB_W-1:0]  PROB_MIN   = 12'd63;
  localparam logic [PROB_W-1:0]  PROB_MAX   = 12'd4033;

  // request codes
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_BIN  = 1'b1;

  typedef struct packed {
    logic               bit_val;
    logic               need_byte;
    logic [STATE_W-1:0] state;
    logic [PROB_W-1:0]  p_next;
  } bin_result_t;

endpackage

>>> hdl/ctxrans_bin_unit.sv
// Arithmetic of one binary rANS bin: split, state update, probability adaptation.
// Depends on ctxrans_pkg.
`timescale 1ns / 1ps

module ctxrans_bin_unit
  import ctxrans_pkg::*;
(
  input  logic [STATE_W-1:0] state,
  input  logic [PROB_W-1:0]  prob,
  input  logic               adaptive,
  output bin_result_t        result
);

  logic [SCALE_W-1:0]   freq1;
  logic [SCALE_W:0]     freq0;
  logic [SCALE_W-1:0]   cum;
  logic [17:0]          hi;
  logic                 bit_val;
  logic [32:0]          prod0;
  logic [32:0]          prod1;
  logic [SCALE_W-1:0]   cum_off;
  logic [STATE_W-1:0]   state_new;
  logic [PROB_W:0]      up_gap;
  logic [PROB_W-1:0]    p_eff;

  always_comb begin
    p_eff   = adaptive ? prob : PROB_HALF;
    freq1   = {p_eff, 2'b00};
    freq0   = 15'd16384 - {1'b0, freq1};
    cum     = state[SCALE_W-1:0];
    hi      = state[STATE_W-1:SCALE_W];
    bit_val = ({1'b0, cum} >= freq0);
    prod0   = 33'(freq0) * 33'(hi);
    prod1   = 33'(freq1) * 33'(hi);
    cum_off = SCALE_W'({1'b0, cum} - freq0);
    if (bit_val) begin
      state_new = prod1[STATE_W-1:0] + STATE_W'(cum_off);
    end else begin
      state_new = prod0[STATE_W-1:0] + STATE_W'(cum);
    end
    up_gap = 13'd4096 - {1'b0, p_eff};

    result.bit_val   = bit_val;
    result.state     = state_new;
    result.need_byte = (state_new[STATE_W-1:23] == '0);
    if (bit_val) begin
      result.p_next = p_eff + PROB_W'(up_gap >> 6);
    end else begin
      result.p_next = p_eff - (p_eff >> 6);
    end
  end

endmodule

>>> hdl/context_adaptive_binary_rans_decoder_top.sv
// Top level of the context-adaptive binary rANS decoder: request pipeline,
// probability table memory, coder state and result register.
// Depends on ctxrans_pkg and ctxrans_bin_unit.
`timescale 1ns / 1ps

// Channel   Direction  Handshake               Payload
// request   in         in_valid / in_ready     req_type, stream_byte, context_req
// result    out        out_valid / out_ready   decoded_bit, need_byte
//
// One request per cycle sustained, bytes and bins alike, while no bin is held
// by an unclaimed result. The request edge issues the table read; the next
// cycle runs the bin (one multiply and add on the coder state) and writes the
// adapted probability back, loading the bin's result into the output register.
// Reset clears the coder state, byte count and table valid bits; an unwritten
// entry reads as half probability. No clearing pass.
// An unclaimed result holds a bin in the stage, and the input with it; a byte
// request in the stage moves on regardless.

module context_adaptive_binary_rans_decoder_top
  import ctxrans_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             req_type,
  input  logic [7:0]       stream_byte,
  input  logic [CTX_W-1:0] context_req,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             decoded_bit,
  output logic             need_byte
);

  // probability table
  logic [PROB_W-1:0] prob_mem [CONTEXTS];
  logic [CONTEXTS-1:0] prob_ok;      // entry written since reset
  logic [PROB_W-1:0] prob_rdata;
  logic              mem_we;
  logic [CTX_AW-1:0] mem_waddr;

  // forwarding of a write that lands on the edge of the read
  logic              fwd;
  logic [PROB_W-1:0] fwd_p;

  // bin / byte stage
  logic              s1_valid;
  logic              s1_type;
  logic [7:0]        s1_byte;
  logic [CTX_W-1:0]  s1_ctx;
  logic              s1_adaptive;
  logic              s1_advance;
  logic [PROB_W-1:0] s1_prob;

  logic [STATE_W-1:0] coder_state;
  logic [2:0]         init_cnt;
  logic [STATE_W-1:0] byte_state;

  bin_result_t bin_res;
  logic        in_fire;
  logic        in_adaptive;

  assign in_fire     = in_valid && in_ready;
  assign in_adaptive = (context_req != FIXED_CTX) && (32'(context_req) < CONTEXTS);

  // a bin waits while a previous result is still unclaimed
  assign s1_advance = s1_valid && ((s1_type == REQ_BYTE) || !out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;

  assign mem_we    = s1_advance && (s1_type == REQ_BIN) && s1_adaptive;
  assign mem_waddr = CTX_AW'(s1_ctx);

  // forwarded value wins, then written entries, else reset value
  always_comb begin
    if (fwd) begin
      s1_prob = fwd_p;
    end else if (prob_ok[CTX_AW'(s1_ctx)]) begin
      s1_prob = prob_rdata;
    end else begin
      s1_prob = PROB_HALF;
    end
  end

  ctxrans_bin_unit u_bin (
    .state    (coder_state),
    .prob     (s1_prob),
    .adaptive (s1_adaptive),
    .result   (bin_res)
  );

  // byte load: first four fill LSB first, later ones shift in
  always_comb begin
    byte_state = coder_state;
    case (init_cnt)
      3'd0:    byte_state = coder_state | STATE_W'(s1_byte);
      3'd1:    byte_state = coder_state | (STATE_W'(s1_byte) << 8);
      3'd2:    byte_state = coder_state | (STATE_W'(s1_byte) << 16);
      3'd3:    byte_state = coder_state | (STATE_W'(s1_byte) << 24);
      default: byte_state = {coder_state[STATE_W-9:0], s1_byte};
    endcase
  end

  // table memory: one read port, one write port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      prob_mem[mem_waddr] <= bin_res.p_next;
    end
    if (in_fire) begin
      prob_rdata <= prob_mem[CTX_AW'(context_req)];
      fwd        <= mem_we && (mem_waddr == CTX_AW'(context_req));
      fwd_p      <= bin_res.p_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prob_ok <= '0;
    end else if (mem_we) begin
      prob_ok[mem_waddr] <= 1'b1;
    end
  end

  // request stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_type     <= req_type;
      s1_byte     <= stream_byte;
      s1_ctx      <= context_req;
      s1_adaptive <= in_adaptive;
    end
  end

  // coder state and init byte count
  always_ff @(posedge clk) begin
    if (rst) begin
      coder_state <= '0;
      init_cnt    <= '0;
    end else if (s1_advance) begin
      if (s1_type == REQ_BYTE) begin
        coder_state <= byte_state;
        if (init_cnt < 3'd4) begin
          init_cnt <= init_cnt + 3'd1;
        end
      end else begin
        coder_state <= bin_res.state;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance && (s1_type == REQ_BIN)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && (s1_type == REQ_BIN)) begin
      decoded_bit <= bin_res.bit_val;
      need_byte   <= bin_res.need_byte;
    end
  end

  // ---------------------------------------------------------------------
  // assertions

  a_init_cnt_range: assert property (@(posedge clk) disable iff (rst)
    init_cnt <= 3'd4)
    else $error("init byte count beyond four");

  a_prob_range: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && (s1_type == REQ_BIN) && s1_adaptive)
      |-> (s1_prob >= PROB_MIN) && (s1_prob <= PROB_MAX))
    else $error("adaptive probability out of range, forwarding slip");

  a_bin_gives_result: assert property (@(posedge clk) disable iff (rst)
    (s1_advance && (s1_type == REQ_BIN)) |=> out_valid)
    else $error("bin left the stage without a result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !(s1_advance && (s1_type == REQ_BIN)))
    else $error("unclaimed result overwritten");

endmodule
